[rtl/core/qrm_pkg.sv]
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared constants for the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

  // default widths
  localparam int IN_WIDTH_DEF      = 16;
  localparam int OUT_FRAC_BITS_DEF = 16;

  // nine matrix entries, ten distinct component products
  localparam int N_ENTRY = 9;
  localparam int N_PROD  = 10;

  // product slots
  localparam int P_AA = 0;
  localparam int P_BB = 1;
  localparam int P_CC = 2;
  localparam int P_DD = 3;
  localparam int P_BC = 4;
  localparam int P_AD = 5;
  localparam int P_BD = 6;
  localparam int P_AC = 7;
  localparam int P_CD = 8;
  localparam int P_AB = 9;

  // entry slots, row major
  localparam int E_00 = 0;
  localparam int E_01 = 1;
  localparam int E_02 = 2;
  localparam int E_10 = 3;
  localparam int E_11 = 4;
  localparam int E_12 = 5;
  localparam int E_20 = 6;
  localparam int E_21 = 7;
  localparam int E_22 = 8;

endpackage

[rtl/core/qrm_quat_if.sv]
// ----------------------------------------------------------------------------
// qrm_quat_if
// Quaternion word channel: valid/ready handshake with four signed components.
// ----------------------------------------------------------------------------
interface qrm_quat_if #(
  parameter int IN_WIDTH = qrm_pkg::IN_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] q_w;
  logic signed [IN_WIDTH-1:0] q_x;
  logic signed [IN_WIDTH-1:0] q_y;
  logic signed [IN_WIDTH-1:0] q_z;

  modport source (output valid, output q_w, output q_x, output q_y, output q_z,
                  input ready);
  modport sink   (input valid, input q_w, input q_x, input q_y, input q_z,
                  output ready);
endinterface

[rtl/core/qrm_mat_if.sv]
// ----------------------------------------------------------------------------
// qrm_mat_if
// Rotation matrix word channel: valid/ready handshake, nine signed entries
// and a zero-norm flag.
// ----------------------------------------------------------------------------
interface qrm_mat_if #(
  parameter int OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [OUT_FRAC_BITS+1:0] m00;
  logic signed [OUT_FRAC_BITS+1:0] m01;
  logic signed [OUT_FRAC_BITS+1:0] m02;
  logic signed [OUT_FRAC_BITS+1:0] m10;
  logic signed [OUT_FRAC_BITS+1:0] m11;
  logic signed [OUT_FRAC_BITS+1:0] m12;
  logic signed [OUT_FRAC_BITS+1:0] m20;
  logic signed [OUT_FRAC_BITS+1:0] m21;
  logic signed [OUT_FRAC_BITS+1:0] m22;
  logic                            zero_norm;

  modport source (output valid, output m00, output m01, output m02,
                  output m10, output m11, output m12, output m20, output m21,
                  output m22, output zero_norm, input ready);
  modport sink   (input valid, input m00, input m01, input m02,
                  input m10, input m11, input m12, input m20, input m21,
                  input m22, input zero_norm, output ready);
endinterface

[rtl/core/quaternion_to_rotation_matrix_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Converts a fixed-point quaternion into a 3x3 rotation matrix in signed
// Q1.OUT_FRAC_BITS, dividing each numerator by the squared norm with
// round-to-nearest and saturation to +-1.0.
// ----------------------------------------------------------------------------
// Stages: one product stage, one sum stage, OUT_FRAC_BITS + 2 restoring
//   divider steps (one quotient bit each, nine lanes side by side), one
//   rounding/output stage.
// Throughput: one word per cycle; a stall at the output holds every stage.
// Reset: synchronous, clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit #(
  parameter int IN_WIDTH      = qrm_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  qrm_quat_if.sink   quat,
  qrm_mat_if.source  mat
);
  import qrm_pkg::*;

  localparam int PW    = 2 * IN_WIDTH;        // product width
  localparam int NW    = PW + 3;              // signed numerator width
  localparam int R_W   = PW + 1;              // magnitude / remainder width
  localparam int QW    = OUT_FRAC_BITS + 2;   // quotient plus round bit
  localparam int OW    = OUT_FRAC_BITS + 2;   // output entry width
  localparam int NSTEP = OUT_FRAC_BITS + 2;   // divider steps

  localparam logic [QW-1:0] LIM = QW'(1) << OUT_FRAC_BITS;

  // pipeline advance: output register free or being drained
  logic en;
  assign en         = !mat.valid || mat.ready;
  assign quat.ready = en;

  // --------------------------------------------------------------------------
  // stage 1: component products
  // --------------------------------------------------------------------------
  logic                 v1;
  logic signed [PW-1:0] prod [N_PROD];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= quat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod[P_AA] <= quat.q_w * quat.q_w;
      prod[P_BB] <= quat.q_x * quat.q_x;
      prod[P_CC] <= quat.q_y * quat.q_y;
      prod[P_DD] <= quat.q_z * quat.q_z;
      prod[P_BC] <= quat.q_x * quat.q_y;
      prod[P_AD] <= quat.q_w * quat.q_z;
      prod[P_BD] <= quat.q_x * quat.q_z;
      prod[P_AC] <= quat.q_w * quat.q_y;
      prod[P_CD] <= quat.q_y * quat.q_z;
      prod[P_AB] <= quat.q_w * quat.q_x;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: norm, numerators, sign and magnitude
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] px [N_PROD];
  logic signed [NW-1:0] num [N_ENTRY];
  logic signed [NW-1:0] norm;
  logic                 v2;
  logic [R_W-1:0]       mag2 [N_ENTRY];
  logic                 neg2 [N_ENTRY];
  logic [R_W-1:0]       den2;
  logic                 zero2;

  always_comb begin
    for (int i = 0; i < N_PROD; i++) begin
      px[i] = NW'(prod[i]);
    end
    norm      = (px[P_AA] + px[P_BB]) + (px[P_CC] + px[P_DD]);
    num[E_00] = (px[P_AA] + px[P_BB]) - (px[P_CC] + px[P_DD]);
    num[E_01] = (px[P_BC] - px[P_AD]) <<< 1;
    num[E_02] = (px[P_BD] + px[P_AC]) <<< 1;
    num[E_10] = (px[P_BC] + px[P_AD]) <<< 1;
    num[E_11] = (px[P_AA] + px[P_CC]) - (px[P_BB] + px[P_DD]);
    num[E_12] = (px[P_CD] - px[P_AB]) <<< 1;
    num[E_20] = (px[P_BD] - px[P_AC]) <<< 1;
    num[E_21] = (px[P_CD] + px[P_AB]) <<< 1;
    num[E_22] = (px[P_AA] + px[P_DD]) - (px[P_BB] + px[P_CC]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den2  <= norm[R_W-1:0];
      zero2 <= (norm == '0);
      for (int k = 0; k < N_ENTRY; k++) begin
        neg2[k] <= num[k][NW-1];
        mag2[k] <= num[k][NW-1] ? R_W'(-num[k]) : num[k][R_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // divider stages: one restoring step per stage in each of the nine lanes
  // --------------------------------------------------------------------------
  logic [NSTEP-1:0] dv_v;
  logic [R_W-1:0]   dv_r    [NSTEP][N_ENTRY];
  logic [QW-1:0]    dv_q    [NSTEP][N_ENTRY];
  logic             dv_neg  [NSTEP][N_ENTRY];
  logic [R_W-1:0]   dv_den  [NSTEP];
  logic             dv_zero [NSTEP];

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    logic             v_in;
    logic [R_W-1:0]   den_in;
    logic             zero_in;
    logic [R_W:0]     rin  [N_ENTRY];
    logic [QW-1:0]    qin  [N_ENTRY];
    logic             nin  [N_ENTRY];
    logic [R_W:0]     diff [N_ENTRY];
    logic             ge   [N_ENTRY];

    // operand source: sum stage or previous step
    if (s == 0) begin : g_first
      always_comb begin
        v_in    = v2;
        den_in  = den2;
        zero_in = zero2;
        for (int k = 0; k < N_ENTRY; k++) begin
          rin[k] = {1'b0, mag2[k]};
          qin[k] = '0;
          nin[k] = neg2[k];
        end
      end
    end else begin : g_next
      always_comb begin
        v_in    = dv_v[s-1];
        den_in  = dv_den[s-1];
        zero_in = dv_zero[s-1];
        for (int k = 0; k < N_ENTRY; k++) begin
          rin[k] = {dv_r[s-1][k], 1'b0};
          qin[k] = dv_q[s-1][k];
          nin[k] = dv_neg[s-1][k];
        end
      end
    end

    // compare and subtract
    always_comb begin
      for (int k = 0; k < N_ENTRY; k++) begin
        diff[k] = rin[k] - {1'b0, den_in};
        ge[k]   = (rin[k] >= {1'b0, den_in});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[s] <= 1'b0;
      end else if (en) begin
        dv_v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[s]  <= den_in;
        dv_zero[s] <= zero_in;
        for (int k = 0; k < N_ENTRY; k++) begin
          dv_r[s][k]   <= ge[k] ? diff[k][R_W-1:0] : rin[k][R_W-1:0];
          dv_q[s][k]   <= {qin[k][QW-2:0], ge[k]};
          dv_neg[s][k] <= nin[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output stage: round, saturate, restore sign
  // --------------------------------------------------------------------------
  logic                 out_v;
  logic signed [OW-1:0] out_m [N_ENTRY];
  logic                 out_zero;
  logic [QW-1:0]        qr   [N_ENTRY];
  logic [QW-1:0]        qs   [N_ENTRY];
  logic signed [OW-1:0] m_next [N_ENTRY];

  always_comb begin
    for (int k = 0; k < N_ENTRY; k++) begin
      qr[k] = {1'b0, dv_q[NSTEP-1][k][QW-1:1]} + QW'(dv_q[NSTEP-1][k][0]);
      qs[k] = (qr[k] > LIM) ? LIM : qr[k];
      if (dv_zero[NSTEP-1]) begin
        m_next[k] = '0;
      end else if (dv_neg[NSTEP-1][k]) begin
        m_next[k] = -$signed(OW'(qs[k]));
      end else begin
        m_next[k] = $signed(OW'(qs[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv_v[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_zero <= dv_zero[NSTEP-1];
      for (int k = 0; k < N_ENTRY; k++) begin
        out_m[k] <= m_next[k];
      end
    end
  end

  assign mat.valid     = out_v;
  assign mat.zero_norm = out_zero;
  assign mat.m00       = out_m[E_00];
  assign mat.m01       = out_m[E_01];
  assign mat.m02       = out_m[E_02];
  assign mat.m10       = out_m[E_10];
  assign mat.m11       = out_m[E_11];
  assign mat.m12       = out_m[E_12];
  assign mat.m20       = out_m[E_20];
  assign mat.m21       = out_m[E_21];
  assign mat.m22       = out_m[E_22];

`ifndef SYNTHESIS
  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !mat.valid)
    else $error("output word valid right after reset");

  // a stall freezes every valid bit ahead of the output register
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({v1, v2, dv_v}))
    else $error("pipeline valid bits moved during a stall");

  // the entry 00 remainder stays below the divisor at the last step
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dv_v[NSTEP-1] && !dv_zero[NSTEP-1] |->
      dv_r[NSTEP-1][E_00] < dv_den[NSTEP-1])
    else $error("divider remainder not below norm");

  // zero quaternion gives an all-zero matrix
  a_zero_matrix: assert property (@(posedge clk) disable iff (rst)
    mat.valid && mat.zero_norm |->
      mat.m00 == '0 && mat.m01 == '0 && mat.m02 == '0 &&
      mat.m10 == '0 && mat.m11 == '0 && mat.m12 == '0 &&
      mat.m20 == '0 && mat.m21 == '0 && mat.m22 == '0)
    else $error("zero-norm word with nonzero entries");
`endif

endmodule
